FILE: hw/rtl/msmc_pkg.sv
`timescale 1ns / 1ps

package msmc_pkg;

    // Field widths
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned POT_W   = 12;
    localparam int unsigned SPD_W   = 7;
    localparam int unsigned DRIVE_W = 8;
    localparam int unsigned DIR_W   = 2;

    // Potentiometer full-scale reading
    localparam int unsigned POT_FULL_SCALE_DEFAULT = 4095;

    // Top speed in percent
    localparam logic [SPD_W-1:0] SPEED_MAX = 7'd100;

    // Mapped keypad characters
    localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
    localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
    localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
    localparam logic [KEY_W-1:0] KEY_1    = 8'h31;
    localparam logic [KEY_W-1:0] KEY_2    = 8'h32;
    localparam logic [KEY_W-1:0] KEY_6    = 8'h36;

    // Direction codes
    localparam logic signed [DIR_W-1:0] DIR_CW    = 2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_CCW   = -2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_UNSET = 2'sd0;

    // Operating modes
    typedef enum logic [2:0] {
        MODE_STOP    = 3'd0,
        MODE_KEY_DIR = 3'd1,
        MODE_KEY_SPD = 3'd2,
        MODE_POT_DIR = 3'd3,
        MODE_POT_SPD = 3'd4
    } mode_t;

endpackage

FILE: hw/rtl/msmc_pot_scale.sv
`timescale 1ns / 1ps

// Converts a pot reading to percent: floor(100 * pot / full scale), capped at 100.
// The constant divide is a multiply by a rounded-up reciprocal, exact for
// every numerator the pot can produce.
module msmc_pot_scale #(
    parameter int unsigned POT_FULL_SCALE = msmc_pkg::POT_FULL_SCALE_DEFAULT
) (
    input  logic [msmc_pkg::POT_W-1:0] pot,
    output logic [msmc_pkg::SPD_W-1:0] speed
);

    // Largest numerator 100 * pot
    localparam longint unsigned NUM_MAX = 100 * ((64'd1 << msmc_pkg::POT_W) - 64'd1);
    localparam int unsigned NUM_W = $clog2(NUM_MAX + 1);
    localparam int unsigned L     = $clog2(POT_FULL_SCALE);
    localparam int unsigned SH    = NUM_W + L;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(POT_FULL_SCALE) - 64'd1) / 64'(POT_FULL_SCALE);
    // Fold the factor 100 into the constant
    localparam longint unsigned COEF = 100 * RECIP;
    localparam int unsigned COEF_W = $clog2(COEF + 1);
    localparam int unsigned PROD_W = msmc_pkg::POT_W + COEF_W;
    localparam int unsigned QW     = 16;

    logic [PROD_W-1:0] prod;
    logic [QW-1:0]     quot;

    // Scale and cap
    always_comb
    begin
        prod = PROD_W'(pot) * PROD_W'(COEF);
        quot = QW'(prod >> SH);
        if (quot > QW'(msmc_pkg::SPEED_MAX))
        begin
            speed = msmc_pkg::SPEED_MAX;
        end
        else
        begin
            speed = quot[msmc_pkg::SPD_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/motor_speed_mode_controller.sv
`timescale 1ns / 1ps

// Motor speed and mode controller. Each request is one poll (key, back button,
// pot sample) and yields exactly one result showing mode, speed, direction and
// the signed drive command with its update flag. A request is registered in the
// input stage at accept and its result in the state and result registers; a new
// request is taken every cycle unless an untaken result stalls the stage, and
// the mode update feeds back into the next poll. The pot percent is a
// constant-reciprocal multiply set by POT_FULL_SCALE.
module motor_speed_mode_controller #(
    parameter int unsigned POT_FULL_SCALE = msmc_pkg::POT_FULL_SCALE_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [msmc_pkg::KEY_W-1:0]            key_code,
    input  logic                                  back_pressed,
    input  logic [msmc_pkg::POT_W-1:0]            pot_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [msmc_pkg::DRIVE_W-1:0]   motor_drive,
    output logic                                  drive_update,
    output logic [2:0]                            mode,
    output logic [msmc_pkg::SPD_W-1:0]            speed_percent,
    output logic signed [msmc_pkg::DIR_W-1:0]     direction
);

    // Input stage
    logic                          s1_valid_reg;
    logic [msmc_pkg::KEY_W-1:0]    s1_key_reg;
    logic                          s1_back_reg;
    logic [msmc_pkg::POT_W-1:0]    s1_pot_reg;

    // Controller state, also the result payload
    msmc_pkg::mode_t                        mode_reg, mode_next;
    logic [msmc_pkg::SPD_W-1:0]             speed_reg, speed_next;
    logic signed [msmc_pkg::DIR_W-1:0]      direction_reg, direction_next;
    logic signed [msmc_pkg::DRIVE_W-1:0]    drive_reg, drive_next;
    logic                                   update_reg, update_next;
    logic                                   out_valid_reg;

    logic                          advance;
    logic                          is_dir_key;
    logic signed [msmc_pkg::DIR_W-1:0] key_dir;
    logic [msmc_pkg::SPD_W-1:0]    pot_speed;

    // Signed drive from direction and speed
    function automatic logic signed [msmc_pkg::DRIVE_W-1:0] drive_of(
        input logic signed [msmc_pkg::DIR_W-1:0] dir,
        input logic [msmc_pkg::SPD_W-1:0]        spd
    );
        logic signed [msmc_pkg::DRIVE_W-1:0] mag;
        mag = signed'(msmc_pkg::DRIVE_W'(spd));
        case (dir)
            msmc_pkg::DIR_CW:  drive_of = mag;
            msmc_pkg::DIR_CCW: drive_of = -mag;
            default:           drive_of = '0;
        endcase
    endfunction

    msmc_pot_scale #(
        .POT_FULL_SCALE(POT_FULL_SCALE)
    ) u_pot_scale (
        .pot   (s1_pot_reg),
        .speed (pot_speed)
    );

    // Handshake: the stage moves when the result slot is free or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_key_reg  <= key_code;
            s1_back_reg <= back_pressed;
            s1_pot_reg  <= pot_sample;
        end
    end

    // Mode update for one poll
    assign is_dir_key = (s1_key_reg == msmc_pkg::KEY_STAR) ||
                        (s1_key_reg == msmc_pkg::KEY_HASH);
    assign key_dir    = (s1_key_reg == msmc_pkg::KEY_STAR) ? msmc_pkg::DIR_CW
                                                           : msmc_pkg::DIR_CCW;

    always_comb
    begin
        mode_next      = mode_reg;
        speed_next     = speed_reg;
        direction_next = direction_reg;
        drive_next     = drive_reg;
        update_next    = 1'b0;

        unique case (mode_reg) inside
            msmc_pkg::MODE_KEY_DIR, msmc_pkg::MODE_POT_DIR:
            begin
                // direction key wins over back
                if (is_dir_key)
                begin
                    direction_next = key_dir;
                    mode_next = (mode_reg == msmc_pkg::MODE_KEY_DIR) ?
                                msmc_pkg::MODE_KEY_SPD : msmc_pkg::MODE_POT_SPD;
                end
                else if (s1_back_reg)
                begin
                    mode_next      = msmc_pkg::MODE_STOP;
                    speed_next     = '0;
                    direction_next = msmc_pkg::DIR_UNSET;
                    drive_next     = '0;
                    update_next    = 1'b1;
                end
            end
            msmc_pkg::MODE_KEY_SPD:
            begin
                if (s1_key_reg != msmc_pkg::KEY_NONE)
                begin
                    if (is_dir_key)
                    begin
                        direction_next = key_dir;
                    end
                    else if (s1_key_reg == msmc_pkg::KEY_0)
                    begin
                        speed_next = '0;
                    end
                    else if ((s1_key_reg >= msmc_pkg::KEY_1) &&
                             (s1_key_reg <= msmc_pkg::KEY_6))
                    begin
                        // '1'..'6' -> 50..100 in steps of 10
                        speed_next = msmc_pkg::SPD_W'(7'd40 + 7'd10 * s1_key_reg[2:0]);
                    end
                    drive_next  = drive_of(direction_next, speed_next);
                    update_next = 1'b1;
                end
                if (s1_back_reg)
                begin
                    mode_next      = msmc_pkg::MODE_STOP;
                    speed_next     = '0;
                    direction_next = msmc_pkg::DIR_UNSET;
                    drive_next     = '0;
                    update_next    = 1'b1;
                end
            end
            msmc_pkg::MODE_POT_SPD:
            begin
                if (is_dir_key)
                begin
                    direction_next = key_dir;
                end
                // issue a command only on a speed change
                if (pot_speed != speed_reg)
                begin
                    speed_next  = pot_speed;
                    drive_next  = drive_of(direction_next, pot_speed);
                    update_next = 1'b1;
                end
                if (s1_back_reg)
                begin
                    mode_next      = msmc_pkg::MODE_STOP;
                    speed_next     = '0;
                    direction_next = msmc_pkg::DIR_UNSET;
                    drive_next     = '0;
                    update_next    = 1'b1;
                end
            end
            default:
            begin
                // stopped, and any unused code
                if (s1_key_reg == msmc_pkg::KEY_1)
                begin
                    mode_next = msmc_pkg::MODE_KEY_DIR;
                end
                else if (s1_key_reg == msmc_pkg::KEY_2)
                begin
                    mode_next = msmc_pkg::MODE_POT_DIR;
                end
                else
                begin
                    mode_next = msmc_pkg::MODE_STOP;
                end
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= msmc_pkg::MODE_STOP;
            speed_reg     <= '0;
            direction_reg <= msmc_pkg::DIR_UNSET;
            drive_reg     <= '0;
            update_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                mode_reg      <= mode_next;
                speed_reg     <= speed_next;
                direction_reg <= direction_next;
                drive_reg     <= drive_next;
                update_reg    <= update_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_drive   = drive_reg;
    assign drive_update  = update_reg;
    assign mode          = mode_reg;
    assign speed_percent = speed_reg;
    assign direction     = direction_reg;

endmodule
